[hw/rtl/smtp_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding median time past: shared definitions
// Field widths and default window depth used by the block and its channels.
// ----------------------------------------------------------------------------
package smtp_pkg;

   localparam int TIME_W     = 32;
   localparam int HELD_W     = 4;
   localparam int WINDOW_DEF = 11;

endpackage

[hw/rtl/smtp_if.sv]
// ----------------------------------------------------------------------------
// Sliding median time past: channel interfaces
// Valid/ready channels for timestamp requests and median responses.
// ----------------------------------------------------------------------------
interface smtp_req_if import smtp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] block_time;

   modport source (output valid, output block_time, input ready);
   modport sink (input valid, input block_time, output ready);
endinterface

interface smtp_rsp_if import smtp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] median_time;
   logic [HELD_W-1:0] held_count;

   modport source (output valid, output median_time, output held_count, input ready);
   modport sink (input valid, input median_time, input held_count, output ready);
endinterface

[hw/rtl/smtp_ram.sv]
// ----------------------------------------------------------------------------
// Sliding median time past: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smtp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sliding_median_time_past.sv]
// ----------------------------------------------------------------------------
// Sliding median time past
// Median of the most recent WINDOW block timestamps, upper middle when even.
// ----------------------------------------------------------------------------
// Each request on req_bus carries one timestamp. It is written into a ring of
// WINDOW entries held in a single-port-read RAM, replacing the oldest entry
// once the ring is full. The block then answers on rsp_bus with the median of
// the n timestamps held and with n itself, masked to four bits.
// The median is found by rank: each held entry in turn is read as a candidate
// and compared against all n entries, one RAM read per cycle, until one is
// found whose rank range covers n/2. Each candidate passes through the LOAD,
// CAPT, SCAN and EVAL states, and the found median goes through DONE into the
// output register; the one RAM read port sets the pace of this search.
// One request is worked on at a time; req_bus.ready is high whenever no
// request is in progress, even while a finished response waits.
// A stalled response holds in the output register and the block waits for it
// to be taken before it presents the next one. Reset empties the window and
// drops any pending response; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_median_time_past import smtp_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic       clock,
   input  logic       reset,
   smtp_req_if.sink   req_bus,
   smtp_rsp_if.source rsp_bus
);

   localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW = $clog2(WINDOW + 1);
   localparam int HW = (CW > HELD_W) ? CW : HELD_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_CAPT = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_EVAL = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [AW-1:0]     cand_idx_ff, cand_idx_in;
   logic [TIME_W-1:0] cand_val_ff, cand_val_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic [CW-1:0]     less_ff, less_in;
   logic [CW-1:0]     eq_ff, eq_in;
   logic [TIME_W-1:0] result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] median_ff, median_in;
   logic [HELD_W-1:0] held_ff, held_in;

   logic              accept;
   logic [AW-1:0]     rd_addr;
   logic [TIME_W-1:0] rd_data;
   logic [CW-1:0]     half;
   logic [CW:0]       upper;
   logic [HW-1:0]     fill_ext;

   smtp_ram #(
      .WIDTH (TIME_W),
      .DEPTH (WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (req_bus.block_time),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign accept              = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.median_time = median_ff;
   assign rsp_bus.held_count  = held_ff;

   assign half     = fill_ff >> 1;
   assign upper    = {1'b0, less_ff} + {1'b0, eq_ff};
   assign fill_ext = HW'(fill_ff);

   always_comb begin
      unique case (state_ff)
         S_LOAD:  rd_addr = cand_idx_ff;
         S_SCAN:  rd_addr = (scan_ff < fill_ff) ? scan_ff[AW-1:0] : '0;
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      cand_idx_in  = cand_idx_ff;
      cand_val_in  = cand_val_ff;
      scan_in      = scan_ff;
      less_in      = less_ff;
      eq_in        = eq_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff;
      median_in    = median_ff;
      held_in      = held_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               slot_in     = (slot_ff == AW'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
               fill_in     = (fill_ff < CW'(WINDOW)) ? fill_ff + 1'b1 : fill_ff;
               cand_idx_in = '0;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_CAPT;
         end
         S_CAPT: begin
            cand_val_in = rd_data;
            scan_in     = CW'(1);
            less_in     = '0;
            eq_in       = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            less_in = less_ff + CW'(rd_data < cand_val_ff);
            eq_in   = eq_ff + CW'(rd_data == cand_val_ff);
            if (scan_ff == fill_ff) begin
               state_in = S_EVAL;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_EVAL: begin
            if ((less_ff <= half) && (upper > {1'b0, half})) begin
               result_in = cand_val_ff;
               state_in  = S_DONE;
            end else begin
               cand_idx_in = cand_idx_ff + 1'b1;
               state_in    = S_LOAD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               median_in    = result_ff;
               held_in      = fill_ext[HELD_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_idx_ff <= cand_idx_in;
      cand_val_ff <= cand_val_in;
      scan_ff     <= scan_in;
      less_ff     <= less_in;
      eq_ff       <= eq_in;
      result_ff   <= result_in;
      median_ff   <= median_in;
      held_ff     <= held_in;
   end

endmodule

[hw/rtl/smtp_check.sv]
// ----------------------------------------------------------------------------
// Sliding median time past: port checker
// Concurrent assertions on the request and response ports over time.
// ----------------------------------------------------------------------------
module smtp_check import smtp_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [TIME_W-1:0] rsp_median_time,
   input logic [HELD_W-1:0] rsp_held_count
);

   // A stalled response must keep its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_median_time) && $stable(rsp_held_count))
      else $error("Response payload changed while stalled.");

   // Reset drops any pending response.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   // When the window is below sixteen, the count reported is nonzero and lies within the window.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (WINDOW < 16) |-> (rsp_held_count != '0) &&
         (rsp_held_count <= HELD_W'(WINDOW)))
      else $error("Held count outside the window.");

   // A response cannot appear in the cycle after a request is accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("Response appeared too early.");

endmodule

bind sliding_median_time_past smtp_check #(
   .WINDOW (WINDOW)
) u_smtp_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_median_time (rsp_bus.median_time),
   .rsp_held_count  (rsp_bus.held_count)
);

[dv/sliding_median_time_past_test.sv]
// ----------------------------------------------------------------------------
// Sliding median time past: block-level test
// Drives timestamp requests with random gaps and response stalls, predicts the
// median and held count of every request and checks each response in order.
// ----------------------------------------------------------------------------
module sliding_median_time_past_test import smtp_pkg::*;;

   localparam int WINDOW        = WINDOW_DEF;
   localparam int IDLE_LIMIT    = 5000;
   localparam int TAIL_CYCLES   = 200;
   localparam int RANDOM_ITEMS  = 530;
   localparam int HOLD_AFTER    = 200;
   localparam int HOLD_CYCLES   = 600;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [TIME_W-1:0] median_time;
      logic [HELD_W-1:0] held_count;
   } median_rsp_type;

   class median_scoreboard_type;
      logic [TIME_W-1:0] held_times[WINDOW];
      int                next_slot;
      int                fill;
      median_rsp_type    expected_q[$];
      int                mismatches;

      function new();
         foreach (held_times[i]) held_times[i] = '0;
         next_slot  = 0;
         fill       = 0;
         mismatches = 0;
      endfunction

      function void note_request(logic [TIME_W-1:0] block_time);
         logic [TIME_W-1:0] sorted[WINDOW];
         logic [TIME_W-1:0] v;
         median_rsp_type    rsp;
         int                j;
         held_times[next_slot] = block_time;
         next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
         if (fill < WINDOW) fill++;
         for (int i = 0; i < fill; i++) begin
            v = held_times[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
               sorted[j] = sorted[j-1];
               j--;
            end
            sorted[j] = v;
         end
         rsp.median_time = sorted[fill / 2];
         rsp.held_count  = HELD_W'(fill);
         expected_q = {expected_q, rsp};
      endfunction

      function void check_response(logic [TIME_W-1:0] median_time,
                                   logic [HELD_W-1:0] held_count);
         median_rsp_type exp_rsp;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: median_time=%h held_count=%0d",
                        median_time, held_count);
            return;
         end
         exp_rsp = expected_q.pop_front();
         if (median_time !== exp_rsp.median_time || held_count !== exp_rsp.held_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch: median_time exp=%h got=%h, held_count exp=%0d got=%0d",
                        exp_rsp.median_time, median_time, exp_rsp.held_count, held_count);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   smtp_req_if req_bus();
   smtp_rsp_if rsp_bus();

   sliding_median_time_past #(.WINDOW(WINDOW)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   median_scoreboard_type sb = new();
   int                    requests_taken = 0;
   int                    idle_cycles    = 0;
   bit                    hold_done      = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   // Every rising edge: note accepted requests, check taken responses, watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles++;
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            sb.note_request(req_bus.block_time);
            requests_taken++;
            idle_cycles = 0;
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            sb.check_response(rsp_bus.median_time, rsp_bus.held_count);
            idle_cycles = 0;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [TIME_W-1:0] block_time);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.block_time <= block_time;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // The receiver stalls at random and once holds off long enough to back up the input.
   initial begin
      int run;
      int gap;
      rsp_bus.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && requests_taken >= HOLD_AFTER) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1;
            @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         run = $urandom_range(1, 8);
         repeat (run - 1) @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
      end
   end

   initial begin
      logic [TIME_W-1:0] directed[$];
      logic [TIME_W-1:0] chain;
      logic [TIME_W-1:0] t;
      int                mode;
      int                burst;
      int                sent;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.block_time <= '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Window filling from empty through the first wrap, then duplicates and order changes.
      directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
                   32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'h0000_0000,
                   32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005,
                   32'h0000_0005, 32'h0000_0005, 32'h6000_0000, 32'h5000_0000,
                   32'h4000_0000, 32'h3000_0000, 32'h2000_0000, 32'h1000_0000};
      foreach (directed[i]) send_request(directed[i]);

      chain = 32'h5F00_0000;
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         mode  = $urandom_range(0, 99);
         burst = $urandom_range(5, 40);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            if (mode < 40) begin
               chain = chain + $urandom_range(0, 1200);
               t = chain;
            end else if (mode < 65) begin
               t = $urandom();
            end else if (mode < 80) begin
               t = $urandom_range(0, 3);
            end else if (mode < 90) begin
               case ($urandom_range(0, 3))
                  0: t = 32'h0000_0000;
                  1: t = 32'hFFFF_FFFF;
                  2: t = 32'h8000_0000;
                  default: t = 32'h7FFF_FFFF;
               endcase
            end else begin
               chain = chain + $urandom_range(0, 1200);
               t = ($urandom_range(0, 3) == 0) ? chain - $urandom_range(0, 7200) : chain;
            end
            send_request(t);
            sent++;
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) sb.mismatches++;
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/smtp_pkg.sv
hw/rtl/smtp_if.sv
hw/rtl/smtp_ram.sv
hw/rtl/sliding_median_time_past.sv
hw/rtl/smtp_check.sv
dv/sliding_median_time_past_test.sv
